// ----- design/tcc_pkg.sv -----
// Shared widths and reset values for the touch coordinate conditioner.
package tcc_pkg;

    localparam int BYTE_W     = 8;
    localparam int CAL_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CAL_W-1:0]  RST_THRESHOLD = CAL_W'(3);
    localparam logic [CAL_W-1:0]  RST_X_LOW     = CAL_W'(60);
    localparam logic [CAL_W-1:0]  RST_X_HIGH    = CAL_W'(980);
    localparam logic [CAL_W-1:0]  RST_Y_LOW     = CAL_W'(100);
    localparam logic [CAL_W-1:0]  RST_Y_HIGH    = CAL_W'(900);
    localparam logic [SIZE_W-1:0] RST_WIDTH     = SIZE_W'(800);
    localparam logic [SIZE_W-1:0] RST_HEIGHT    = SIZE_W'(480);

endpackage

// ----- design/tcc_sample_if.sv -----
// Raw touch sample channel.
interface tcc_sample_if;
    import tcc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] x_high_byte;
    logic [BYTE_W-1:0] y_high_byte;
    logic [BYTE_W-1:0] xy_low_byte;

    modport source (output valid, x_high_byte, y_high_byte, xy_low_byte, input ready);
    modport sink   (input valid, x_high_byte, y_high_byte, xy_low_byte, output ready);
endinterface

// ----- design/tcc_result_if.sv -----
// Calibrated position result channel.
interface tcc_result_if #(
    parameter int RAW_W = 10
);
    import tcc_pkg::*;

    logic              valid;
    logic              ready;
    logic              position_updated;
    logic [SIZE_W-1:0] x_position;
    logic [SIZE_W-1:0] y_position;
    logic [RAW_W-1:0]  x_raw;
    logic [RAW_W-1:0]  y_raw;

    modport source (output valid, position_updated, x_position, y_position, x_raw, y_raw,
                    input ready);
    modport sink   (input valid, position_updated, x_position, y_position, x_raw, y_raw,
                    output ready);
endinterface

// ----- design/tcc_cfg_if.sv -----
// Configuration register write channel.
interface tcc_cfg_if;
    import tcc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/touch_coordinate_conditioner.sv -----
// Touch coordinate conditioner: raw touch samples to calibrated screen position.
//
// sample: one raw touch reading per item (X/Y high bytes, shared low-bit byte).
// result: one item per sample with the update flag, the held X/Y pixel
//         position and the assembled raw X/Y of that sample.
// cfg:    register writes (index, data), always ready; write only while idle.
//
// Each sample is handled by a small sequencer around one shared multiplier
// and one radix-4 restoring divider (two quotient bits per cycle). A sample
// that does not move the position goes from idle straight to the finish
// state, which loads the output register. A recompute multiplies and
// divides X, then Y, then finishes; in averaging mode the group's last
// sample first multiplies by the divide-by-AVG_SAMPLES reciprocal, X then Y.
// sample is ready only while the sequencer is idle. The result sits in an
// output register, so a new sample can be taken while it waits; a stalled
// receiver holds the next finished result in the sequencer until taken.
// Reset loads the documented register defaults and clears all history.
module touch_coordinate_conditioner #(
    parameter int ADC_BITS    = 10,
    parameter int AVG_SAMPLES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    tcc_sample_if.sink          sample,
    tcc_result_if.source        result,
    tcc_cfg_if.sink             cfg
);
    import tcc_pkg::*;

    localparam int LOW_BITS = ADC_BITS - 8;
    localparam int DIFF_W   = (ADC_BITS > CAL_W) ? ADC_BITS : CAL_W;
    localparam int CNT_W    = $clog2(AVG_SAMPLES);
    localparam int SUM_W    = ADC_BITS + CNT_W;
    localparam int REC_K    = SUM_W + 5;
    localparam longint REC_M = ((longint'(1) << REC_K) + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam int MA_W     = (DIFF_W > SUM_W) ? DIFF_W : SUM_W;
    localparam int MB_W     = (SIZE_W > REC_K) ? SIZE_W : REC_K;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int NUM_W0   = DIFF_W + SIZE_W;
    localparam int NUM_W    = NUM_W0 + (NUM_W0 % 2);
    localparam int STEPS    = NUM_W / 2;
    localparam int STEP_W   = $clog2(STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_X_LOW       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW       = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = CFG_IDX_W'(7);

    localparam logic MODE_DEADBAND = 1'b0;

    localparam logic [15:0] LOW_MASK = 16'((1 << LOW_BITS) - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_AX,
        ST_MUL_AY,
        ST_MUL_X,
        ST_DIV_X,
        ST_MUL_Y,
        ST_DIV_Y,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;

    logic                 mode_reg, mode_next;
    logic [CAL_W-1:0]     thr_reg, thr_next;
    logic [CAL_W-1:0]     x_low_reg, x_low_next;
    logic [CAL_W-1:0]     x_high_reg, x_high_next;
    logic [CAL_W-1:0]     y_low_reg, y_low_next;
    logic [CAL_W-1:0]     y_high_reg, y_high_next;
    logic [SIZE_W-1:0]    width_reg, width_next;
    logic [SIZE_W-1:0]    height_reg, height_next;

    logic [ADC_BITS-1:0]  prev_x_reg, prev_x_next;
    logic [ADC_BITS-1:0]  prev_y_reg, prev_y_next;
    logic [SIZE_W-1:0]    held_x_reg, held_x_next;
    logic [SIZE_W-1:0]    held_y_reg, held_y_next;
    logic [SUM_W-1:0]     sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]     sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 upd_reg, upd_next;
    logic [ADC_BITS-1:0]  arg_x_reg, arg_x_next;
    logic [ADC_BITS-1:0]  arg_y_reg, arg_y_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [CAL_W-1:0]     rem_reg, rem_next;
    logic                 zero_reg, zero_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    logic                 res_valid_reg, res_valid_next;
    logic                 res_upd_reg, res_upd_next;
    logic [SIZE_W-1:0]    res_x_pos_reg, res_x_pos_next;
    logic [SIZE_W-1:0]    res_y_pos_reg, res_y_pos_next;
    logic [ADC_BITS-1:0]  res_x_raw_reg, res_x_raw_next;
    logic [ADC_BITS-1:0]  res_y_raw_reg, res_y_raw_next;

    logic [15:0]          x_wide, y_wide;
    logic [ADC_BITS-1:0]  raw_x, raw_y;
    logic [ADC_BITS-1:0]  dx, dy;
    logic [ADC_BITS:0]    pair_x, pair_y;
    logic [DIFF_W-1:0]    off_x, off_y;
    logic [MA_W-1:0]      mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [PROD_W-1:0]    prod;
    logic [CAL_W-1:0]     div_d;
    logic [CAL_W:0]       t1, t2;
    logic [CAL_W-1:0]     r1, r2;
    logic                 q1, q2;
    logic [NUM_W-1:0]     quo;
    logic [SIZE_W-1:0]    clamp_size;
    logic [SIZE_W-1:0]    mapped;

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    assign result.valid            = res_valid_reg;
    assign result.position_updated = res_upd_reg;
    assign result.x_position       = res_x_pos_reg;
    assign result.y_position       = res_y_pos_reg;
    assign result.x_raw            = res_x_raw_reg;
    assign result.y_raw            = res_y_raw_reg;

    // raw sample assembly
    assign x_wide = ({8'h00, sample.x_high_byte} << LOW_BITS)
                  | ({8'h00, sample.xy_low_byte} & LOW_MASK);
    assign y_wide = ({8'h00, sample.y_high_byte} << LOW_BITS)
                  | (({8'h00, sample.xy_low_byte} >> LOW_BITS) & LOW_MASK);
    assign raw_x  = x_wide[ADC_BITS-1:0];
    assign raw_y  = y_wide[ADC_BITS-1:0];

    assign dx = (prev_x_reg > raw_x) ? (prev_x_reg - raw_x) : (raw_x - prev_x_reg);
    assign dy = (prev_y_reg > raw_y) ? (prev_y_reg - raw_y) : (raw_y - prev_y_reg);

    assign pair_x = {1'b0, prev_x_reg} + {1'b0, raw_x};
    assign pair_y = {1'b0, prev_y_reg} + {1'b0, raw_y};

    assign off_x = DIFF_W'(arg_x_reg) - DIFF_W'(x_low_reg);
    assign off_y = DIFF_W'(arg_y_reg) - DIFF_W'(y_low_reg);

    // shared multiplier
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // shared divider, two restoring steps per cycle
    assign div_d = (state_reg == ST_DIV_Y) ? (y_high_reg - y_low_reg)
                                           : (x_high_reg - x_low_reg);
    assign t1 = {rem_reg, num_reg[NUM_W-1]};
    assign q1 = (t1 >= {1'b0, div_d});
    assign r1 = q1 ? CAL_W'(t1 - {1'b0, div_d}) : t1[CAL_W-1:0];
    assign t2 = {r1, num_reg[NUM_W-2]};
    assign q2 = (t2 >= {1'b0, div_d});
    assign r2 = q2 ? CAL_W'(t2 - {1'b0, div_d}) : t2[CAL_W-1:0];
    assign quo = {num_reg[NUM_W-3:0], q1, q2};

    assign clamp_size = (state_reg == ST_DIV_Y) ? height_reg : width_reg;
    assign mapped = zero_reg ? '0
                  : (quo > NUM_W'(clamp_size)) ? clamp_size : quo[SIZE_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        thr_next       = thr_reg;
        x_low_next     = x_low_reg;
        x_high_next    = x_high_reg;
        y_low_next     = y_low_reg;
        y_high_next    = y_high_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        count_next     = count_reg;
        upd_next       = upd_reg;
        arg_x_next     = arg_x_reg;
        arg_y_next     = arg_y_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        zero_next      = zero_reg;
        step_next      = step_reg;
        res_valid_next = res_valid_reg;
        res_upd_next   = res_upd_reg;
        res_x_pos_next = res_x_pos_reg;
        res_y_pos_next = res_y_pos_reg;
        res_x_raw_next = res_x_raw_reg;
        res_y_raw_next = res_y_raw_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_FILTER_MODE: mode_next   = cfg.data[0];
                REG_THRESHOLD:   thr_next    = cfg.data[CAL_W-1:0];
                REG_X_LOW:       x_low_next  = cfg.data[CAL_W-1:0];
                REG_X_HIGH:      x_high_next = cfg.data[CAL_W-1:0];
                REG_Y_LOW:       y_low_next  = cfg.data[CAL_W-1:0];
                REG_Y_HIGH:      y_high_next = cfg.data[CAL_W-1:0];
                REG_WIDTH:       width_next  = cfg.data[SIZE_W-1:0];
                REG_HEIGHT:      height_next = cfg.data[SIZE_W-1:0];
                default:         ;
            endcase
        end

        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    prev_x_next = raw_x;
                    prev_y_next = raw_y;
                    if (mode_reg == MODE_DEADBAND)
                    begin
                        if ((DIFF_W'(dx) > DIFF_W'(thr_reg)) || (DIFF_W'(dy) > DIFF_W'(thr_reg)))
                        begin
                            arg_x_next = raw_x;
                            arg_y_next = raw_y;
                            upd_next   = 1'b1;
                            state_next = ST_MUL_X;
                        end
                        else
                        begin
                            upd_next   = 1'b0;
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        sum_x_next = sum_x_reg + SUM_W'(pair_x[ADC_BITS:1]);
                        sum_y_next = sum_y_reg + SUM_W'(pair_y[ADC_BITS:1]);
                        if (count_reg == CNT_W'(AVG_SAMPLES - 1))
                        begin
                            count_next = '0;
                            upd_next   = 1'b1;
                            state_next = ST_MUL_AX;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            upd_next   = 1'b0;
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_MUL_AX:
            begin
                // sum / AVG_SAMPLES by reciprocal, exact over the sum's range
                mul_a      = MA_W'(sum_x_reg);
                mul_b      = MB_W'(REC_M);
                arg_x_next = prod[REC_K +: ADC_BITS];
                state_next = ST_MUL_AY;
            end
            ST_MUL_AY:
            begin
                mul_a      = MA_W'(sum_y_reg);
                mul_b      = MB_W'(REC_M);
                arg_y_next = prod[REC_K +: ADC_BITS];
                sum_x_next = '0;
                sum_y_next = '0;
                state_next = ST_MUL_X;
            end
            ST_MUL_X:
            begin
                mul_a      = MA_W'(off_x);
                mul_b      = MB_W'(width_reg);
                num_next   = NUM_W'(prod[NUM_W0-1:0]);
                rem_next   = '0;
                zero_next  = (x_high_reg <= x_low_reg)
                          || (DIFF_W'(arg_x_reg) <= DIFF_W'(x_low_reg));
                step_next  = '0;
                state_next = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                num_next  = quo;
                rem_next  = r2;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    held_x_next = mapped;
                    state_next  = ST_MUL_Y;
                end
            end
            ST_MUL_Y:
            begin
                mul_a      = MA_W'(off_y);
                mul_b      = MB_W'(height_reg);
                num_next   = NUM_W'(prod[NUM_W0-1:0]);
                rem_next   = '0;
                zero_next  = (y_high_reg <= y_low_reg)
                          || (DIFF_W'(arg_y_reg) <= DIFF_W'(y_low_reg));
                step_next  = '0;
                state_next = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                num_next  = quo;
                rem_next  = r2;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    held_y_next = mapped;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_upd_next   = upd_reg;
                    res_x_pos_next = held_x_reg;
                    res_y_pos_next = held_y_reg;
                    res_x_raw_next = prev_x_reg;
                    res_y_raw_next = prev_y_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_DEADBAND;
            thr_reg       <= RST_THRESHOLD;
            x_low_reg     <= RST_X_LOW;
            x_high_reg    <= RST_X_HIGH;
            y_low_reg     <= RST_Y_LOW;
            y_high_reg    <= RST_Y_HIGH;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            upd_reg       <= 1'b0;
            arg_x_reg     <= '0;
            arg_y_reg     <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            zero_reg      <= 1'b0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_upd_reg   <= 1'b0;
            res_x_pos_reg <= '0;
            res_y_pos_reg <= '0;
            res_x_raw_reg <= '0;
            res_y_raw_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            thr_reg       <= thr_next;
            x_low_reg     <= x_low_next;
            x_high_reg    <= x_high_next;
            y_low_reg     <= y_low_next;
            y_high_reg    <= y_high_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
            upd_reg       <= upd_next;
            arg_x_reg     <= arg_x_next;
            arg_y_reg     <= arg_y_next;
            num_reg       <= num_next;
            rem_reg       <= rem_next;
            zero_reg      <= zero_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
            res_upd_reg   <= res_upd_next;
            res_x_pos_reg <= res_x_pos_next;
            res_y_pos_reg <= res_y_pos_next;
            res_x_raw_reg <= res_x_raw_next;
            res_y_raw_reg <= res_y_raw_next;
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for touch_coordinate_conditioner with its own position predictor.
`timescale 1ns / 100ps

module testbench;
    import tcc_pkg::*;

    localparam int ADC_BITS    = 10;
    localparam int AVG_SAMPLES = 4;
    localparam int RAW_W       = ADC_BITS;
    localparam int LOW_BITS    = ADC_BITS - 8;
    localparam int RAW_MAX     = (1 << ADC_BITS) - 1;
    localparam int NUM_REGS    = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_PAUSE = 40;
    localparam int MAX_REPORTS = 10;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE,
        REG_MOVE_THRESHOLD,
        REG_X_ADC_LOW,
        REG_X_ADC_HIGH,
        REG_Y_ADC_LOW,
        REG_Y_ADC_HIGH,
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT
    } cal_reg_e;

    typedef enum logic {
        MODE_DEADBAND = 1'b0,
        MODE_AVERAGE  = 1'b1
    } filter_mode_e;

    typedef struct packed {
        logic              position_updated;
        logic [SIZE_W-1:0] x_position;
        logic [SIZE_W-1:0] y_position;
        logic [RAW_W-1:0]  x_raw;
        logic [RAW_W-1:0]  y_raw;
    } touch_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tcc_sample_if                   sample_bus ();
    tcc_result_if #(.RAW_W(RAW_W))  result_bus ();
    tcc_cfg_if                      cfg_bus ();

    touch_coordinate_conditioner #(
        .ADC_BITS    (ADC_BITS),
        .AVG_SAMPLES (AVG_SAMPLES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    filter_mode_e      cal_mode      = MODE_DEADBAND;
    logic [CAL_W-1:0]  cal_threshold = RST_THRESHOLD;
    logic [CAL_W-1:0]  cal_x_low     = RST_X_LOW;
    logic [CAL_W-1:0]  cal_x_high    = RST_X_HIGH;
    logic [CAL_W-1:0]  cal_y_low     = RST_Y_LOW;
    logic [CAL_W-1:0]  cal_y_high    = RST_Y_HIGH;
    logic [SIZE_W-1:0] cal_width     = RST_WIDTH;
    logic [SIZE_W-1:0] cal_height    = RST_HEIGHT;
    logic [RAW_W-1:0]  last_x        = '0;
    logic [RAW_W-1:0]  last_y        = '0;
    logic [SIZE_W-1:0] hold_x        = '0;
    logic [SIZE_W-1:0] hold_y        = '0;
    int unsigned       sum_x         = 0;
    int unsigned       sum_y         = 0;
    int unsigned       group_count   = 0;

    touch_result_t         expected_positions [$];
    logic [CFG_DATA_W-1:0] pending_regs [NUM_REGS];
    int                    mismatch_count = 0;
    bit                    no_idle        = 1'b0;
    bit                    hold_request   = 1'b0;

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void apply_reg(input cal_reg_e idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FILTER_MODE:    cal_mode      = filter_mode_e'(data[0]);
            REG_MOVE_THRESHOLD: cal_threshold = data[CAL_W-1:0];
            REG_X_ADC_LOW:      cal_x_low     = data[CAL_W-1:0];
            REG_X_ADC_HIGH:     cal_x_high    = data[CAL_W-1:0];
            REG_Y_ADC_LOW:      cal_y_low     = data[CAL_W-1:0];
            REG_Y_ADC_HIGH:     cal_y_high    = data[CAL_W-1:0];
            REG_SCREEN_WIDTH:   cal_width     = data[SIZE_W-1:0];
            REG_SCREEN_HEIGHT:  cal_height    = data[SIZE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
                                                     input logic [CAL_W-1:0] lo,
                                                     input logic [CAL_W-1:0] hi,
                                                     input logic [SIZE_W-1:0] size);
        longint unsigned q;
        if (hi <= lo || raw <= lo)
            return '0;
        q = (64'(raw) - 64'(lo)) * 64'(size) / (64'(hi) - 64'(lo));
        if (q > 64'(size))
            q = 64'(size);
        return q[SIZE_W-1:0];
    endfunction

    function automatic touch_result_t predict_position(input logic [BYTE_W-1:0] xh,
                                                       input logic [BYTE_W-1:0] yh,
                                                       input logic [BYTE_W-1:0] lb);
        touch_result_t    r;
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        int unsigned      dx;
        int unsigned      dy;
        rx = {xh, lb[LOW_BITS-1:0]};
        ry = {yh, lb[2*LOW_BITS-1:LOW_BITS]};
        r.position_updated = 1'b0;
        if (cal_mode == MODE_DEADBAND)
        begin
            dx = 32'((last_x > rx) ? last_x - rx : rx - last_x);
            dy = 32'((last_y > ry) ? last_y - ry : ry - last_y);
            last_x = rx;
            last_y = ry;
            if (dx > 32'(cal_threshold) || dy > 32'(cal_threshold))
            begin
                hold_x = scale_axis(rx, cal_x_low, cal_x_high, cal_width);
                hold_y = scale_axis(ry, cal_y_low, cal_y_high, cal_height);
                r.position_updated = 1'b1;
            end
        end
        else
        begin
            sum_x = sum_x + ((32'(last_x) + 32'(rx)) >> 1);
            sum_y = sum_y + ((32'(last_y) + 32'(ry)) >> 1);
            last_x = rx;
            last_y = ry;
            group_count++;
            if (group_count >= AVG_SAMPLES)
            begin
                hold_x = scale_axis(RAW_W'(sum_x / AVG_SAMPLES), cal_x_low, cal_x_high, cal_width);
                hold_y = scale_axis(RAW_W'(sum_y / AVG_SAMPLES), cal_y_low, cal_y_high, cal_height);
                sum_x = 0;
                sum_y = 0;
                group_count = 0;
                r.position_updated = 1'b1;
            end
        end
        r.x_position = hold_x;
        r.y_position = hold_y;
        r.x_raw      = rx;
        r.y_raw      = ry;
        return r;
    endfunction

    function automatic int unsigned nudge(input int unsigned base, input int unsigned span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - int'(span);
        if (v < 0)
            v = 0;
        if (v > RAW_MAX)
            v = RAW_MAX;
        return v;
    endfunction

    // valid stays high after acceptance so back-to-back items need no extra edge
    task automatic send_sample(input logic [BYTE_W-1:0] xh, input logic [BYTE_W-1:0] yh,
                               input logic [BYTE_W-1:0] lb);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.x_high_byte <= xh;
        sample_bus.y_high_byte <= yh;
        sample_bus.xy_low_byte <= lb;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        expected_positions.push_back(predict_position(xh, yh, lb));
    endtask

    task automatic send_raw(input int unsigned rx, input int unsigned ry);
        logic [BYTE_W-1:0] lb;
        lb = BYTE_W'($urandom);
        lb[LOW_BITS-1:0]          = rx[LOW_BITS-1:0];
        lb[2*LOW_BITS-1:LOW_BITS] = ry[LOW_BITS-1:0];
        send_sample(BYTE_W'(rx >> LOW_BITS), BYTE_W'(ry >> LOW_BITS), lb);
    endtask

    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mode, thr, xl, xh, yl, yh, w, h);
        wait_drained();
        pending_regs[REG_FILTER_MODE]    = mode;
        pending_regs[REG_MOVE_THRESHOLD] = thr;
        pending_regs[REG_X_ADC_LOW]      = xl;
        pending_regs[REG_X_ADC_HIGH]     = xh;
        pending_regs[REG_Y_ADC_LOW]      = yl;
        pending_regs[REG_Y_ADC_HIGH]     = yh;
        pending_regs[REG_SCREEN_WIDTH]   = w;
        pending_regs[REG_SCREEN_HEIGHT]  = h;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= cal_reg_e'(i);
            cfg_bus.data  <= pending_regs[i];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            apply_reg(cal_reg_e'(i), pending_regs[i]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic configure_default(input filter_mode_e mode, input logic [CAL_W-1:0] thr);
        configure(CFG_DATA_W'(mode), CFG_DATA_W'(thr), CFG_DATA_W'(RST_X_LOW),
                  CFG_DATA_W'(RST_X_HIGH), CFG_DATA_W'(RST_Y_LOW), CFG_DATA_W'(RST_Y_HIGH),
                  RST_WIDTH, RST_HEIGHT);
    endtask

    task automatic randomize_calibration(input int phase);
        logic [CFG_DATA_W-1:0] mode, thr, xl, xh, yl, yh, w, h, t;
        int r;
        mode = CFG_DATA_W'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 60)
            thr = CFG_DATA_W'($urandom_range(0, 12));
        else if (r < 85)
            thr = CFG_DATA_W'($urandom_range(13, 200));
        else if (r < 93)
            thr = '0;
        else
            thr = CFG_DATA_W'(RAW_MAX);
        xl = CFG_DATA_W'($urandom_range(0, 400));
        xh = CFG_DATA_W'($urandom_range(600, RAW_MAX));
        yl = CFG_DATA_W'($urandom_range(0, 400));
        yh = CFG_DATA_W'($urandom_range(600, RAW_MAX));
        if ($urandom_range(0, 9) == 0)
        begin
            t = xl; xl = xh; xh = t;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            t = yl; yl = yh; yh = t;
        end
        if ($urandom_range(0, 7) == 0)
            xh = xl;
        w = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 2047));
        h = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 2047));
        if (phase == 0)
        begin
            mode = CFG_DATA_W'(MODE_AVERAGE);
            thr = '0;
            xl = '0; xh = CFG_DATA_W'(RAW_MAX); yl = '0; yh = CFG_DATA_W'(RAW_MAX);
            w = CFG_DATA_W'(2047); h = CFG_DATA_W'(2047);
        end
        else if (phase == PHASES - 1)
        begin
            mode = CFG_DATA_W'(MODE_DEADBAND);
            thr = CFG_DATA_W'(1);
            xl = CFG_DATA_W'(RAW_MAX - 1); xh = CFG_DATA_W'(RAW_MAX);
            yl = '0; yh = CFG_DATA_W'(1);
            w = CFG_DATA_W'(1); h = CFG_DATA_W'(2047);
        end
        // bits above a register's width must be dropped
        if ($urandom_range(0, 3) == 0)
        begin
            mode = mode | (CFG_DATA_W'($urandom) & 11'h7FE);
            thr[CAL_W] = 1'($urandom_range(0, 1));
            xl[CAL_W]  = 1'($urandom_range(0, 1));
            xh[CAL_W]  = 1'($urandom_range(0, 1));
            yl[CAL_W]  = 1'($urandom_range(0, 1));
            yh[CAL_W]  = 1'($urandom_range(0, 1));
        end
        configure(mode, thr, xl, xh, yl, yh, w, h);
    endtask

    task automatic random_sample();
        int r;
        int unsigned span;
        r = $urandom_range(0, 99);
        span = cal_threshold + 2;
        if (r < 70)
            send_raw(nudge(32'(last_x), span), nudge(32'(last_y), span));
        else if (r < 88)
            send_raw($urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX));
        else
            send_sample(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic test_reset_defaults();
        send_raw(0, 0);
        send_raw(3, 3);
        send_raw(7, 3);
        send_raw(520, 500);
    endtask

    task automatic test_field_extremes();
        send_sample(8'hFF, 8'hFF, 8'hFF);
        send_sample(8'h00, 8'hFF, 8'h0C);
        send_raw(60, 100);
        send_raw(980, 900);
        send_sample(8'h00, 8'h00, 8'hF0);
    endtask

    task automatic test_calibration_corners();
        // empty X range, inverted Y range
        configure(CFG_DATA_W'(MODE_DEADBAND), '0, CFG_DATA_W'(500), CFG_DATA_W'(500),
                  CFG_DATA_W'(700), CFG_DATA_W'(200), RST_WIDTH, RST_HEIGHT);
        send_raw(700, 300);
        send_raw(400, 900);
        // full range, widest screen, zero height
        configure(CFG_DATA_W'(MODE_DEADBAND), '0, '0, CFG_DATA_W'(RAW_MAX), '0,
                  CFG_DATA_W'(RAW_MAX), CFG_DATA_W'(2047), '0);
        send_raw(RAW_MAX, 512);
        send_raw(1, 1);
        configure_default(MODE_DEADBAND, CAL_W'(RAW_MAX));
        send_raw(RAW_MAX, RAW_MAX);
        send_raw(0, 0);
    endtask

    task automatic test_averaging_groups();
        configure_default(MODE_AVERAGE, RST_THRESHOLD);
        repeat (4) send_raw(RAW_MAX, RAW_MAX);
        send_raw(500, 600);
        send_raw(510, 590);
        send_raw(0, 0);
        send_raw(300, 200);
    endtask

    task automatic test_mode_switch();
        send_raw(400, 400);
        send_raw(420, 380);
        configure_default(MODE_DEADBAND, CAL_W'(5));
        send_raw(430, 390);
        send_raw(600, 700);
        configure_default(MODE_AVERAGE, CAL_W'(5));
        send_raw(610, 710);
        send_raw(200, 100);
    endtask

    task automatic test_backpressure();
        configure_default(MODE_DEADBAND, '0);
        no_idle = 1'b1;
        hold_request = 1'b1;
        repeat (24) random_sample();
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++)
        begin
            randomize_calibration(p);
            no_idle = (p == 2 || p == 5);
            if (p == 4)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                random_sample();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : result_receiver
        int gap;
        int run;
        result_bus.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    result_bus.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            result_bus.ready <= 1'b1;
            run = no_idle ? 16 : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        touch_result_t got;
        touch_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = {result_bus.position_updated, result_bus.x_position, result_bus.y_position,
                   result_bus.x_raw, result_bus.y_raw};
            if (expected_positions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result item: upd=%0d x=%0d y=%0d raw=%0d,%0d",
                             got.position_updated, got.x_position, got.y_position,
                             got.x_raw, got.y_raw);
            end
            else
            begin
                want = expected_positions.pop_front();
                if (got.position_updated !== want.position_updated ||
                    got.x_position !== want.x_position || got.y_position !== want.y_position ||
                    got.x_raw !== want.x_raw || got.y_raw !== want.y_raw)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: exp upd=%0d x=%0d y=%0d raw=%0d,%0d",
                                 want.position_updated, want.x_position, want.y_position,
                                 want.x_raw, want.y_raw,
                                 "  got upd=%0d x=%0d y=%0d raw=%0d,%0d",
                                 got.position_updated, got.x_position, got.y_position,
                                 got.x_raw, got.y_raw);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_bus.valid && sample_bus.ready) ||
                (result_bus.valid && result_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[touch_coordinate_conditioner] ERROR");
        $finish;
    end

    initial
    begin
        sample_bus.valid       <= 1'b0;
        sample_bus.x_high_byte <= '0;
        sample_bus.y_high_byte <= '0;
        sample_bus.xy_low_byte <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.index          <= REG_FILTER_MODE;
        cfg_bus.data           <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_calibration_corners();
        test_averaging_groups();
        test_mode_switch();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (DRAIN_PAUSE) @(posedge clk);
        if (mismatch_count == 0 && expected_positions.size() == 0)
            $display("[touch_coordinate_conditioner] OK");
        else
            $display("[touch_coordinate_conditioner] ERROR");
        $finish;
    end

endmodule
